>>> design/positional_list_store_assert.svh
// ----------------------------------------------------------------------------
// positional_list_store_assert.svh
// Assertion macros used by the list store design
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

  // fixed field widths of the request and response channels
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned LEN_W    = 9;

  // request operations
  typedef enum logic [OPCODE_W-1:0] {
    OP_READ      = 3'd0,
    OP_OVERWRITE = 3'd1,
    OP_INSERT    = 3'd2,
    OP_DELETE    = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_STATUS    = 3'd5
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } state_e;

endpackage

>>> design/pls_if.sv
// ----------------------------------------------------------------------------
// pls_req_if / pls_rsp_if
// Valid/ready channels carrying list requests and their responses
// ----------------------------------------------------------------------------

// request channel
interface pls_req_if import pls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [ITEM_W-1:0]   item_in;

  modport source (output valid, output opcode, output position, output item_in,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_in,
                  output ready);
endinterface

// response channel
interface pls_rsp_if import pls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ITEM_W-1:0] item_out;
  logic [LEN_W-1:0]  length;
  logic              is_empty;

  modport source (output valid, output ok, output item_out, output length,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input item_out, input length,
                  input is_empty, output ready);
endinterface

>>> design/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-clock RAM, one write port and one registered read port
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of words in a RAM, addressed by 1-based position
// ----------------------------------------------------------------------------
// Requests arrive on req_i (valid/ready) carrying an opcode, a 1-based
// position and a data word; every request gives exactly one response on
// rsp_o with ok, the word read or removed, the new length and an empty flag.
// Operations: read, overwrite, insert, delete, clear and status. A request
// outside the valid span, an insert into a full list or an unknown opcode
// returns ok low and leaves the list as it was.
// Clear, status and rejected requests go straight to the response; read
// passes through a lookup, overwrite through a place step, delete through a
// lookup and a shift, and insert through a shift and a place step. Requests
// are handled one at a time: the shift of insert and delete moves one entry
// per cycle through the single read and single write port of the entry RAM.
// A new request is taken as soon as the sequencer is idle, even while the
// previous response is still held in the output register.
// Reset empties the list at once (fill count cleared, no RAM sweep). When
// the receiver stalls, a finished response waits in the output register and
// the sequencer holds its next result until that register is free.
// ----------------------------------------------------------------------------
`include "positional_list_store_assert.svh"

module positional_list_store import pls_pkg::*; #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pls_req_if.sink   req_i,
  pls_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ((CW > POS_W) ? CW : POS_W) + 1;

  // control state
  state_e          state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            out_valid_q, out_valid_d;

  // request context
  op_e             op_q, op_d;
  logic            res_ok_q, res_ok_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [DATA_WIDTH-1:0] item_q, item_d;

  // shift engine
  logic [AW-1:0]   src_q, src_d;
  logic [AW-1:0]   dst_q, dst_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rv_q, rv_d;

  // response register
  logic                 rsp_ok_q, rsp_ok_d;
  logic [ITEM_W-1:0]    rsp_item_q, rsp_item_d;
  logic [LEN_W-1:0]     rsp_len_q, rsp_len_d;
  logic                 rsp_empty_q, rsp_empty_d;

  // RAM ports
  logic                  mem_we;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  // request decode
  logic            req_fire;
  logic            rsp_free;
  logic            shift_done;
  op_e             req_op;
  logic [EW-1:0]   pos_e, fill_e, k_e;
  logic            span_ok, ins_ok;
  logic [EW-1:0]   fill_out_e;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !out_valid_q || rsp_o.ready;
  assign shift_done  = (cnt_q == '0) && !rv_q;

  assign req_op  = op_e'(req_i.opcode);
  assign pos_e   = EW'(req_i.position);
  assign fill_e  = EW'(fill_q);
  assign k_e     = pos_e - EW'(1);
  assign span_ok = (pos_e != '0) && (pos_e <= fill_e);
  assign ins_ok  = (pos_e != '0) && (pos_e <= fill_e + EW'(1))
                   && (fill_e < EW'(CAPACITY));

  // entry store
  pls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_DONE;
          unique case (req_op)
            OP_READ:      if (span_ok) state_d = ST_LOOKUP;
            OP_OVERWRITE: if (span_ok) state_d = ST_PLACE;
            OP_INSERT:    if (ins_ok)  state_d = ST_SHIFT;
            OP_DELETE:    if (span_ok) state_d = ST_LOOKUP;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_LOOKUP: begin
        state_d = (op_q == OP_DELETE) ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (shift_done) begin
          state_d = (op_q == OP_INSERT) ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    fill_d      = fill_q;
    op_d        = op_q;
    res_ok_d    = res_ok_q;
    idx_d       = idx_q;
    word_d      = word_q;
    item_d      = item_q;
    src_d       = src_q;
    dst_d       = dst_q;
    cnt_d       = cnt_q;
    rv_d        = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = idx_q;
    mem_wr_data = word_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = src_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    rsp_ok_d    = rsp_ok_q;
    rsp_item_d  = rsp_item_q;
    rsp_len_d   = rsp_len_q;
    rsp_empty_d = rsp_empty_q;

    unique case (state_q)
      ST_IDLE: begin
        // latch the request and settle ok and the new length up front
        if (req_fire) begin
          op_d     = req_op;
          idx_d    = k_e[AW-1:0];
          word_d   = DATA_WIDTH'(64'(req_i.item_in));
          item_d   = '0;
          res_ok_d = 1'b0;
          cnt_d    = '0;
          unique case (req_op)
            OP_READ: begin
              res_ok_d    = span_ok;
              mem_rd_en   = span_ok;
              mem_rd_addr = k_e[AW-1:0];
            end
            OP_OVERWRITE: begin
              res_ok_d = span_ok;
            end
            OP_INSERT: begin
              res_ok_d = ins_ok;
              if (ins_ok) begin
                fill_d = fill_q + CW'(1);
                cnt_d  = CW'(fill_e - k_e);
                src_d  = AW'(fill_e - EW'(1));
              end
            end
            OP_DELETE: begin
              res_ok_d    = span_ok;
              mem_rd_en   = span_ok;
              mem_rd_addr = k_e[AW-1:0];
              if (span_ok) begin
                fill_d = fill_q - CW'(1);
                cnt_d  = CW'(fill_e - k_e - EW'(1));
                src_d  = AW'(k_e + EW'(1));
              end
            end
            OP_CLEAR: begin
              res_ok_d = 1'b1;
              fill_d   = '0;
            end
            OP_STATUS: begin
              res_ok_d = 1'b1;
            end
            default: res_ok_d = 1'b0;
          endcase
        end
      end
      ST_LOOKUP: begin
        item_d = mem_rd_data;
      end
      ST_SHIFT: begin
        // read one entry ahead, write the previous one to its new slot
        if (cnt_q != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = src_q;
          rv_d        = 1'b1;
          cnt_d       = cnt_q - CW'(1);
          if (op_q == OP_INSERT) begin
            dst_d = src_q + AW'(1);
            src_d = src_q - AW'(1);
          end else begin
            dst_d = src_q - AW'(1);
            src_d = src_q + AW'(1);
          end
        end
        if (rv_q) begin
          mem_we      = 1'b1;
          mem_wr_addr = dst_q;
          mem_wr_data = mem_rd_data;
        end
      end
      ST_PLACE: begin
        mem_we      = 1'b1;
        mem_wr_addr = idx_q;
        mem_wr_data = word_q;
      end
      ST_DONE: begin
        if (rsp_free) begin
          out_valid_d = 1'b1;
          rsp_ok_d    = res_ok_q;
          rsp_item_d  = ITEM_W'(64'(item_q));
          rsp_len_d   = LEN_W'(fill_out_e);
          rsp_empty_d = (fill_q == '0);
        end
      end
      default: ;
    endcase
  end

  assign fill_out_e = EW'(fill_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    res_ok_q    <= res_ok_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    item_q      <= item_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    rsp_ok_q    <= rsp_ok_d;
    rsp_item_q  <= rsp_item_d;
    rsp_len_q   <= rsp_len_d;
    rsp_empty_q <= rsp_empty_d;
  end

  // response channel
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.ok       = rsp_ok_q;
  assign rsp_o.item_out = rsp_item_q;
  assign rsp_o.length   = rsp_len_q;
  assign rsp_o.is_empty = rsp_empty_q;

  // checks
  `PLS_ASSERT(a_fill_bound, 1'b1, fill_e <= EW'(CAPACITY), "fill count beyond capacity")
  `PLS_ASSERT_NEXT(a_leave_idle, req_fire, state_q != ST_IDLE, "request did not start")
  `PLS_ASSERT(a_no_idle_write, (state_q == ST_IDLE) || (state_q == ST_DONE), !mem_we, "write outside op")
  `PLS_ASSERT_NEXT(a_result_out, (state_q == ST_DONE) && rsp_free, out_valid_q, "response lost")

endmodule
